FILE: rtl/stc_pkg.sv
// Shared constants and types for the sphere/triangle contact block.
// No dependencies; imported by every module of the block.
package stc_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int NUM_SLOTS      = 10;

  localparam logic [3:0] SLOT_NORMAL = 4'd3;
  localparam logic [3:0] SLOT_ENORM  = 4'd4;
  localparam logic [3:0] SLOT_DIR    = 4'd7;
  localparam logic [3:0] SLOT_LAST   = 4'd9;

  localparam logic [1:0] REG_SX  = 2'd0;
  localparam logic [1:0] REG_SY  = 2'd1;
  localparam logic [1:0] REG_SZ  = 2'd2;
  localparam logic [1:0] REG_RAD = 2'd3;

  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } stc_req_t;

endpackage

FILE: rtl/stc_root_div.sv
// Bit-serial unit: integer square root of a 64-bit value or unsigned
// 64-by-31-bit division. Depends on stc_pkg.
module stc_root_div import stc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  stc_req_t    req,
  input  logic [63:0] opa,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [63:0] res
);

  logic        running;
  logic        op_r;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] bitv;
  logic [63:0] trial;
  logic [32:0] tr;

  assign trial = res + bitv;
  assign tr    = {rem[31:0], res[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        op_r    <= req.op;
        cnt     <= (req.op == OP_SQRT) ? 7'd32 : 7'd64;
        rem     <= (req.op == OP_SQRT) ? opa : 64'd0;
        res     <= (req.op == OP_SQRT) ? 64'd0 : opa;
        bitv    <= 64'h4000_0000_0000_0000;
      end else if (running) begin
        if (op_r == OP_SQRT) begin
          if (rem >= trial) begin
            rem <= rem - trial;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
        end else begin
          if (tr >= {2'b00, divisor}) begin
            rem <= 64'(tr - {2'b00, divisor});
            res <= {res[62:0], 1'b1};
          end else begin
            rem <= 64'(tr);
            res <= {res[62:0], 1'b0};
          end
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/sphere_triangle_contact.sv
// Sphere against triangle contact test, top level.
// Depends on stc_pkg and stc_root_div.
//
// Usage: write the sphere centre and radius over the APB port (x, y, z,
// radius at byte addresses 0, 4, 8, 12) while the block is idle. Send the
// triangle as ten beats on start/slot/comp_*: corners, face normal, edge
// normals, edge directions with length in w. A beat is taken when start
// is high and busy is low. Beats for slots 0 to 8 only store the row; a
// slot above nine is taken and dropped. The slot 9 beat starts the test:
// busy stays high while one shared 35x35 multiplier runs the dot
// products, edge point and curvature terms, followed by a bit-serial
// square root and divider. One result beat, strobed by done for exactly
// one cycle, follows slot 9: soonest when the plane distance misses,
// later for a face contact, latest when all edges are tried and the
// curvature scale runs. The receiver cannot stall.
// Reset clears the sphere registers and the sequencer; triangle rows hold
// whatever was last written.
module sphere_triangle_contact import stc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         slot,
  input  logic signed [31:0] comp_x,
  input  logic signed [31:0] comp_y,
  input  logic signed [31:0] comp_z,
  input  logic signed [31:0] comp_w,
  output logic               done,
  output logic               hit,
  output logic signed [31:0] contact_nx,
  output logic signed [31:0] contact_ny,
  output logic signed [31:0] contact_nz,
  output logic signed [31:0] contact_px,
  output logic signed [31:0] contact_py,
  output logic signed [31:0] contact_pz,
  output logic [30:0]        depth
);

  localparam int PT_W  = 50;
  localparam int SAT_B = (COORD_BITS < PT_W) ? COORD_BITS : PT_W;
  localparam logic signed [PT_W-1:0] PT_HI =
    {{(PT_W-SAT_B+1){1'b0}}, {(SAT_B-1){1'b1}}};
  localparam logic signed [PT_W-1:0] PT_LO = ~PT_HI;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_RDP   = 5'd1;
  localparam logic [4:0] ST_RDB   = 5'd2;
  localparam logic [4:0] ST_LATB  = 5'd3;
  localparam logic [4:0] ST_SUB   = 5'd4;
  localparam logic [4:0] ST_MUL   = 5'd5;
  localparam logic [4:0] ST_ACC   = 5'd6;
  localparam logic [4:0] ST_CHK   = 5'd7;
  localparam logic [4:0] ST_NEXTE = 5'd8;
  localparam logic [4:0] ST_PMUL  = 5'd9;
  localparam logic [4:0] ST_PACC  = 5'd10;
  localparam logic [4:0] ST_VSET  = 5'd11;
  localparam logic [4:0] ST_HALVE = 5'd12;
  localparam logic [4:0] ST_VMUL  = 5'd13;
  localparam logic [4:0] ST_VACC  = 5'd14;
  localparam logic [4:0] ST_SQ    = 5'd15;
  localparam logic [4:0] ST_SQW   = 5'd16;
  localparam logic [4:0] ST_DV    = 5'd17;
  localparam logic [4:0] ST_DVW   = 5'd18;
  localparam logic [4:0] ST_FMUL  = 5'd19;
  localparam logic [4:0] ST_FACC  = 5'd20;
  localparam logic [4:0] ST_OUT   = 5'd21;

  localparam logic [2:0] PH_DIST = 3'd0;
  localparam logic [2:0] PH_DI   = 3'd1;
  localparam logic [2:0] PH_TI   = 3'd2;
  localparam logic [2:0] PH_PT   = 3'd3;
  localparam logic [2:0] PH_FACE = 3'd4;

  localparam logic signed [PT_W-1:0] V_LIM  = PT_W'(64'sd1073741824);
  localparam logic signed [PT_W-1:0] V_NLIM = -V_LIM;

  function automatic logic [31:0] sat_pt(input logic signed [PT_W-1:0] x);
    logic signed [PT_W-1:0] y;
    begin
      y = (x > PT_HI) ? PT_HI : ((x < PT_LO) ? PT_LO : x);
      return y[31:0];
    end
  endfunction

  function automatic logic [31:0] neg_sat(input logic signed [31:0] x);
    logic signed [32:0] y;
    begin
      y = 33'sd0 - 33'(x);
      return (y == 33'sd2147483648) ? 32'h7FFF_FFFF : y[31:0];
    end
  endfunction

  logic signed [31:0] sx, sy, sz;
  logic [30:0]        rad;

  logic [127:0] mem [NUM_SLOTS];
  logic [127:0] rdata;
  logic [3:0]   rd_addr;

  logic [4:0]  state;
  logic [2:0]  ph;
  logic [3:0]  prow, brow;
  logic [1:0]  c, ei;
  logic [2:0]  dpos;
  logic        sub;
  logic        hit_r;

  logic signed [31:0] preg [3];
  logic signed [31:0] breg [3];
  logic signed [31:0] nreg [3];
  logic signed [31:0] blen;
  logic signed [32:0] dreg;
  logic signed [51:0] acc;
  logic [30:0]        ad;
  logic signed [53:0] pen;
  logic signed [31:0] treg;
  logic signed [PT_W-1:0] pt [3];
  logic signed [PT_W-1:0] v [3];
  logic [63:0]        sq;
  logic signed [63:0] num;
  logic [30:0]        mag;
  logic signed [33:0] factor;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] prod;
  logic signed [53:0] prod_q;

  logic signed [31:0] s_c, preg_c, breg_c, nreg_c;
  logic signed [32:0] negn_c;
  logic signed [PT_W-1:0] v_c;
  logic [51:0]        acc_abs;
  logic signed [51:0] rad_x, len_x, t0, t1;
  logic               v_big;
  logic [63:0]        num_abs;

  stc_req_t    u_req;
  logic        u_done;
  logic [63:0] u_res;

  assign pready = 1'b1;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      sx  <= '0;
      sy  <= '0;
      sz  <= '0;
      rad <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SX:  sx  <= pwdata;
        REG_SY:  sy  <= pwdata;
        REG_SZ:  sz  <= pwdata;
        REG_RAD: rad <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SX:  prdata = sx;
      REG_SY:  prdata = sy;
      REG_SZ:  prdata = sz;
      REG_RAD: prdata = {1'b0, rad};
      default: prdata = '0;
    endcase
  end

  assign rd_addr = (state == ST_RDB) ? brow : prow;

  always_ff @(posedge clk) begin
    if (start && !busy && slot <= SLOT_LAST) begin
      mem[slot] <= {comp_w, comp_z, comp_y, comp_x};
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    case (c)
      2'd0:    s_c = sx;
      2'd1:    s_c = sy;
      default: s_c = sz;
    endcase
    preg_c = preg[c];
    breg_c = breg[c];
    nreg_c = nreg[c];
    v_c    = v[c];
  end

  assign negn_c  = 33'sd0 - 33'(nreg_c);
  assign prod_q  = prod[69:16];
  assign acc_abs = acc[51] ? 52'(-acc) : 52'(acc);
  assign rad_x   = $signed({21'b0, rad});
  assign len_x   = 52'(blen);
  assign t0      = (acc < 52'sd0) ? 52'sd0 : acc;
  assign t1      = (t0 > len_x) ? len_x : t0;
  assign v_big   = (v[0] >= V_LIM) || (v[0] <= V_NLIM) ||
                   (v[1] >= V_LIM) || (v[1] <= V_NLIM) ||
                   (v[2] >= V_LIM) || (v[2] <= V_NLIM);
  assign num_abs = num[63] ? 64'(-num) : 64'(num);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL: begin
        mul_a = 35'(dreg);
        mul_b = 35'(breg_c);
      end
      ST_PMUL: begin
        if (ph == PH_PT) begin
          mul_a = 35'(breg_c);
          mul_b = 35'(treg);
        end else begin
          mul_a = 35'(nreg_c);
          mul_b = $signed({4'b0, ad});
        end
      end
      ST_VMUL: begin
        mul_a = 35'($signed(v_c[30:0]));
        mul_b = sub ? 35'(negn_c) : 35'($signed(v_c[30:0]));
      end
      ST_FMUL: begin
        mul_a = pen[34:0];
        mul_b = 35'(factor);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign u_req.start = (state == ST_SQ) || (state == ST_DV);
  assign u_req.op    = (state == ST_DV) ? OP_DIV : OP_SQRT;

  stc_root_div u_root_div (
    .clk     (clk),
    .rst     (rst),
    .req     (u_req),
    .opa     ((state == ST_DV) ? num_abs : sq),
    .divisor (mag),
    .done    (u_done),
    .res     (u_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hit_r <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && slot == SLOT_LAST) begin
            ph    <= PH_DIST;
            prow  <= 4'd0;
            brow  <= SLOT_NORMAL;
            state <= ST_RDP;
          end
        end
        ST_RDP: state <= ST_RDB;
        ST_RDB: begin
          preg[0] <= rdata[31:0];
          preg[1] <= rdata[63:32];
          preg[2] <= rdata[95:64];
          state   <= ST_LATB;
        end
        ST_LATB: begin
          breg[0] <= rdata[31:0];
          breg[1] <= rdata[63:32];
          breg[2] <= rdata[95:64];
          blen    <= rdata[127:96];
          if (ph == PH_DIST) begin
            nreg[0] <= rdata[31:0];
            nreg[1] <= rdata[63:32];
            nreg[2] <= rdata[95:64];
          end
          c     <= 2'd0;
          acc   <= '0;
          state <= ST_SUB;
        end
        ST_SUB: begin
          dreg  <= 33'(s_c) - 33'(preg_c);
          state <= ST_MUL;
        end
        ST_MUL: state <= ST_ACC;
        ST_ACC: begin
          acc <= acc + 52'(prod_q);
          if (c == 2'd2) begin
            state <= ST_CHK;
          end else begin
            c     <= c + 2'd1;
            state <= ST_SUB;
          end
        end
        ST_CHK: begin
          case (ph)
            PH_DIST: begin
              if (acc_abs > {21'b0, rad}) begin
                hit_r <= 1'b0;
                state <= ST_OUT;
              end else begin
                ad    <= acc_abs[30:0];
                pen   <= $signed({23'b0, rad}) - $signed({23'b0, acc_abs[30:0]});
                ph    <= PH_DI;
                ei    <= 2'd0;
                prow  <= 4'd0;
                brow  <= SLOT_ENORM;
                state <= ST_RDP;
              end
            end
            PH_DI: begin
              dpos[ei] <= (acc > 52'sd0);
              if (acc > rad_x) begin
                hit_r <= 1'b0;
                state <= ST_OUT;
              end else if (ei == 2'd2) begin
                ei    <= 2'd0;
                state <= ST_NEXTE;
              end else begin
                ei    <= ei + 2'd1;
                prow  <= {2'b00, ei} + 4'd1;
                brow  <= SLOT_ENORM + {2'b00, ei} + 4'd1;
                state <= ST_RDP;
              end
            end
            default: begin
              if (acc >= -rad_x && acc < len_x + rad_x) begin
                treg  <= t1[31:0];
                c     <= 2'd0;
                ph    <= PH_PT;
                state <= ST_PMUL;
              end else begin
                ei    <= ei + 2'd1;
                state <= ST_NEXTE;
              end
            end
          endcase
        end
        ST_NEXTE: begin
          if (ei == 2'd3) begin
            ph    <= PH_FACE;
            c     <= 2'd0;
            state <= ST_PMUL;
          end else if (dpos[ei]) begin
            prow  <= {2'b00, ei};
            brow  <= SLOT_DIR + {2'b00, ei};
            ph    <= PH_TI;
            state <= ST_RDP;
          end else begin
            ei <= ei + 2'd1;
          end
        end
        ST_PMUL: state <= ST_PACC;
        ST_PACC: begin
          if (ph == PH_PT) begin
            pt[c] <= PT_W'(preg_c) + PT_W'(prod_q);
          end else begin
            pt[c] <= PT_W'(s_c) - PT_W'(prod_q);
          end
          if (c == 2'd2) begin
            if (ph == PH_PT && pen > 54'sd0) begin
              state <= ST_VSET;
            end else begin
              hit_r <= 1'b1;
              state <= ST_OUT;
            end
          end else begin
            c     <= c + 2'd1;
            state <= ST_PMUL;
          end
        end
        ST_VSET: begin
          v[0]  <= pt[0] - PT_W'(sx);
          v[1]  <= pt[1] - PT_W'(sy);
          v[2]  <= pt[2] - PT_W'(sz);
          state <= ST_HALVE;
        end
        ST_HALVE: begin
          if (v_big) begin
            v[0] <= v[0] >>> 1;
            v[1] <= v[1] >>> 1;
            v[2] <= v[2] >>> 1;
          end else begin
            c     <= 2'd0;
            sub   <= 1'b0;
            sq    <= '0;
            num   <= '0;
            state <= ST_VMUL;
          end
        end
        ST_VMUL: state <= ST_VACC;
        ST_VACC: begin
          if (!sub) begin
            sq    <= sq + prod[63:0];
            sub   <= 1'b1;
            state <= ST_VMUL;
          end else begin
            num <= num + prod[63:0];
            sub <= 1'b0;
            if (c == 2'd2) begin
              state <= ST_SQ;
            end else begin
              c     <= c + 2'd1;
              state <= ST_VMUL;
            end
          end
        end
        ST_SQ: state <= ST_SQW;
        ST_SQW: begin
          if (u_done) begin
            mag <= u_res[30:0];
            if (u_res == 64'd0) begin
              factor <= '0;
              state  <= ST_FMUL;
            end else begin
              state <= ST_DV;
            end
          end
        end
        ST_DV: state <= ST_DVW;
        ST_DVW: begin
          if (u_done) begin
            factor <= num[63] ? -$signed(u_res[33:0]) : $signed(u_res[33:0]);
            state  <= ST_FMUL;
          end
        end
        ST_FMUL: state <= ST_FACC;
        ST_FACC: begin
          pen   <= prod_q;
          hit_r <= 1'b1;
          state <= ST_OUT;
        end
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign hit        = hit_r;
  assign contact_nx = hit_r ? neg_sat(nreg[0]) : 32'd0;
  assign contact_ny = hit_r ? neg_sat(nreg[1]) : 32'd0;
  assign contact_nz = hit_r ? neg_sat(nreg[2]) : 32'd0;
  assign contact_px = hit_r ? sat_pt(pt[0]) : 32'd0;
  assign contact_py = hit_r ? sat_pt(pt[1]) : 32'd0;
  assign contact_pz = hit_r ? sat_pt(pt[2]) : 32'd0;
  assign depth      = !hit_r ? 31'd0 :
                      (pen < 54'sd0) ? 31'd0 :
                      (pen > 54'sd2147483647) ? 31'h7FFF_FFFF : pen[30:0];

  a_strobe_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && slot == SLOT_LAST) |=> busy)
    else $error("slot 9 beat did not start the test");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (depth == 31'd0 && contact_nx == 32'sd0 && contact_px == 32'sd0))
    else $error("miss result carries nonzero fields");

endmodule

FILE: dv/sphere_triangle_contact_tb.sv
// Testbench for sphere_triangle_contact: APB sphere setup, triangle beats, contact checks.
// Depends on stc_pkg and the RTL of the block; predicts each result in fixed point.
module sphere_triangle_contact_tb import stc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic        hit;
    logic [31:0] nx, ny, nz, px, py, pz;
    logic [30:0] depth;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [3:0] slot = '0;
  logic signed [31:0] comp_x = '0, comp_y = '0, comp_z = '0, comp_w = '0;
  logic done, hit;
  logic signed [31:0] contact_nx, contact_ny, contact_nz;
  logic signed [31:0] contact_px, contact_py, contact_pz;
  logic [30:0] depth;

  sphere_triangle_contact dut (.*);

  always #5 clk = ~clk;

  logic [31:0] tri_words [40];
  longint ctr_x, ctr_y, ctr_z, radius;
  contact_t pending_contacts[$];
  int mismatches = 0;
  int cycles = 0;

  function automatic longint word_at(int s, int c);
    return longint'($signed(tri_words[s*4+c]));
  endfunction

  function automatic longint dot16(longint a[3], longint b[3]);
    longint acc = 0;
    for (int c = 0; c < 3; c++) acc += (a[c] * b[c]) >>> 16;
    return acc;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint absl(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic contact_t predict_contact();
    contact_t res;
    longint s[3], n[3], negn[3], e[3], dir[3], pt[3], v[3];
    longint df[3][3], dd[3];
    longint plane_dist, ad, pen, t, len, num, factor, mag;
    longint unsigned sq;
    bit on_edge;
    res = '{default: '0};
    on_edge = 0;
    s[0] = ctr_x; s[1] = ctr_y; s[2] = ctr_z;
    for (int c = 0; c < 3; c++) begin
      n[c] = word_at(SLOT_NORMAL, c);
      negn[c] = -n[c];
      for (int i = 0; i < 3; i++) df[i][c] = s[c] - word_at(i, c);
    end
    plane_dist = dot16(df[0], n);
    ad = absl(plane_dist);
    if (ad > radius) return res;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) e[c] = word_at(SLOT_ENORM + i, c);
      dd[i] = dot16(df[i], e);
      if (dd[i] > radius) return res;
    end
    pen = radius - ad;
    for (int i = 0; i < 3 && !on_edge; i++) begin
      if (dd[i] > 0) begin
        for (int c = 0; c < 3; c++) dir[c] = word_at(SLOT_DIR + i, c);
        len = word_at(SLOT_DIR + i, 3);
        t = dot16(df[i], dir);
        if (t >= -radius && t < len + radius) begin
          if (t < 0) t = 0;
          if (t > len) t = len;
          for (int c = 0; c < 3; c++) pt[c] = word_at(i, c) + ((dir[c] * t) >>> 16);
          if (pen > 0) begin
            for (int c = 0; c < 3; c++) v[c] = pt[c] - s[c];
            while (absl(v[0]) >= (64'sd1 << 30) || absl(v[1]) >= (64'sd1 << 30) ||
                   absl(v[2]) >= (64'sd1 << 30))
              for (int c = 0; c < 3; c++) v[c] = v[c] >>> 1;
            sq = 0;
            num = 0;
            for (int c = 0; c < 3; c++) begin
              sq += longint'(v[c] * v[c]);
              num += v[c] * negn[c];
            end
            mag = root_floor(sq);
            factor = (mag == 0) ? 0 : num / mag;
            pen = (pen * factor) >>> 16;
          end
          on_edge = 1;
        end
      end
    end
    if (!on_edge)
      for (int c = 0; c < 3; c++) pt[c] = s[c] - ((n[c] * ad) >>> 16);
    if (pen < 0) pen = 0;
    if (pen > 64'sd2147483647) pen = 64'sd2147483647;
    res.hit = 1'b1;
    res.nx = sat32(negn[0]); res.ny = sat32(negn[1]); res.nz = sat32(negn[2]);
    res.px = sat32(pt[0]); res.py = sat32(pt[1]); res.pz = sat32(pt[2]);
    res.depth = pen[30:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && done) begin
      if (pending_contacts.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result beat, hit=%0b", hit);
      end else begin
        contact_t exp_c;
        exp_c = pending_contacts.pop_front();
        if (exp_c.hit !== hit || exp_c.nx !== contact_nx || exp_c.ny !== contact_ny ||
            exp_c.nz !== contact_nz || exp_c.px !== contact_px ||
            exp_c.py !== contact_py || exp_c.pz !== contact_pz ||
            exp_c.depth !== depth) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch exp hit=%0b n=%h %h %h p=%h %h %h d=%h / got %0b %h %h %h %h %h %h %h",
                     exp_c.hit, exp_c.nx, exp_c.ny, exp_c.nz, exp_c.px, exp_c.py, exp_c.pz,
                     exp_c.depth, hit, contact_nx, contact_ny, contact_nz,
                     contact_px, contact_py, contact_pz, depth);
        end
      end
    end
  end

  task automatic send_beat(logic [3:0] s, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z, logic [31:0] w);
    start <= 1'b1;
    slot <= s;
    comp_x <= x; comp_y <= y; comp_z <= z; comp_w <= w;
    do @(posedge clk); while (busy);
    if (s <= SLOT_LAST) begin
      tri_words[s*4] = x; tri_words[s*4+1] = y;
      tri_words[s*4+2] = z; tri_words[s*4+3] = w;
      if (s == SLOT_LAST) pending_contacts.push_back(predict_contact());
    end
  endtask

  task automatic hold_idle(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) hold_idle(0);
    else if (r < 93) hold_idle($urandom_range(1, 4));
    else hold_idle($urandom_range(20, 60));
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_contacts.size() != 0 || busy);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SX:  ctr_x = longint'($signed(val));
      REG_SY:  ctr_y = longint'($signed(val));
      REG_SZ:  ctr_z = longint'($signed(val));
      REG_RAD: radius = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic set_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] r);
    drain();
    write_reg(REG_SX, x);
    write_reg(REG_SY, y);
    write_reg(REG_SZ, z);
    write_reg(REG_RAD, r);
  endtask

  function automatic logic [31:0] to_q16(real v);
    real q;
    q = v * 65536.0;
    if (q > 2147483647.0) q = 2147483647.0;
    if (q < -2147483648.0) q = -2147483648.0;
    return 32'($rtoi(q));
  endfunction

  // Consistent triangle near the sphere, in a plane normal to one axis.
  task automatic send_near_triangle(real spread, bit shuffle);
    real p[3][3], d[3][3], e[3][3], ln[3], nrm[3];
    real cx, cy, cz, off, cr, tmp;
    int ax, a1, a2, order[9];
    logic [31:0] rows[10][4];
    ax = $urandom_range(0, 2);
    a1 = (ax + 1) % 3;
    a2 = (ax + 2) % 3;
    cx = $itor(ctr_x) / 65536.0; cy = $itor(ctr_y) / 65536.0; cz = $itor(ctr_z) / 65536.0;
    off = ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread;
    for (int i = 0; i < 3; i++) begin
      p[i][0] = cx + ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread * 2.0;
      p[i][1] = cy + ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread * 2.0;
      p[i][2] = cz + ($itor($urandom_range(0, 2000)) / 1000.0 - 1.0) * spread * 2.0;
      p[i][ax] = (ax == 0 ? cx : ax == 1 ? cy : cz) + off;
    end
    cr = (p[1][a1] - p[0][a1]) * (p[2][a2] - p[0][a2]) -
         (p[1][a2] - p[0][a2]) * (p[2][a1] - p[0][a1]);
    if (cr < 0)
      for (int c = 0; c < 3; c++) begin
        tmp = p[1][c]; p[1][c] = p[2][c]; p[2][c] = tmp;
      end
    for (int c = 0; c < 3; c++) nrm[c] = 0.0;
    nrm[ax] = ($urandom_range(0, 1) != 0) ? 1.0 : -1.0;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) d[i][c] = p[(i+1)%3][c] - p[i][c];
      ln[i] = $sqrt(d[i][0]*d[i][0] + d[i][1]*d[i][1] + d[i][2]*d[i][2]);
      if (ln[i] < 0.001) ln[i] = 0.001;
      for (int c = 0; c < 3; c++) d[i][c] = d[i][c] / ln[i];
      for (int c = 0; c < 3; c++) e[i][c] = 0.0;
      e[i][a1] = d[i][a2];
      e[i][a2] = -d[i][a1];
    end
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        rows[i][c] = to_q16(p[i][c]);
        rows[4+i][c] = to_q16(e[i][c]);
        rows[7+i][c] = to_q16(d[i][c]);
      end
      rows[i][3] = $urandom;
      rows[4+i][3] = $urandom;
      rows[7+i][3] = ($urandom_range(0, 19) == 0) ? -to_q16(ln[i]) : to_q16(ln[i]);
    end
    for (int c = 0; c < 3; c++) rows[3][c] = to_q16(nrm[c]);
    rows[3][3] = $urandom;
    for (int i = 0; i < 9; i++) order[i] = i;
    if (shuffle) order.shuffle();
    for (int i = 0; i < 9; i++) begin
      send_beat(order[i], rows[order[i]][0], rows[order[i]][1], rows[order[i]][2],
                rows[order[i]][3]);
      random_gap();
    end
    send_beat(SLOT_LAST, rows[9][0], rows[9][1], rows[9][2], rows[9][3]);
    random_gap();
  endtask

  task automatic test_extremes();
    set_sphere(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    for (int s = 0; s < 10; s++) begin
      send_beat(s, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    end
    send_beat(4'd10, $urandom, $urandom, $urandom, $urandom);
    send_beat(4'd15, $urandom, $urandom, $urandom, $urandom);
    send_beat(SLOT_LAST, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_beat(SLOT_NORMAL, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0);
    send_beat(SLOT_LAST, 32'h0001_0000, 32'h0, 32'h0, 32'hFFFF_0000);
    set_sphere(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    send_beat(SLOT_LAST, 32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000);
  endtask

  task automatic test_geometry();
    set_sphere(32'h0001_0000, 32'hFFFE_0000, 32'h0000_8000, 32'h0002_0000);
    for (int k = 0; k < 4; k++) send_near_triangle(1.5, 1'b0);
  endtask

  task automatic test_random_triangles();
    for (int ph = 0; ph < 8; ph++) begin
      set_sphere($urandom_range(0, 3) == 0 ? $urandom : to_q16($urandom_range(0, 400) - 200.0),
                 $urandom_range(0, 3) == 0 ? $urandom : to_q16($urandom_range(0, 400) - 200.0),
                 $urandom_range(0, 3) == 0 ? $urandom : to_q16($urandom_range(0, 400) - 200.0),
                 ph == 0 ? 32'h0 : ph == 1 ? 32'h7FFF_FFFF : to_q16($urandom_range(1, 80) / 8.0));
      for (int k = 0; k < 7; k++) begin
        if ($urandom_range(0, 9) < 8)
          send_near_triangle($itor($urandom_range(1, 40)) / 4.0, $urandom_range(0, 1));
        else begin
          for (int b = 0; b < 10; b++) begin
            send_beat($urandom_range(0, 15), $urandom, $urandom, $urandom, $urandom);
            random_gap();
          end
          send_beat(SLOT_LAST, $urandom, $urandom, $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    ctr_x = 0; ctr_y = 0; ctr_z = 0; radius = 0;
    foreach (tri_words[i]) tri_words[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_geometry();
    test_random_triangles();
    drain();
    if (mismatches == 0 && pending_contacts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
